[design/euq_pkg.sv]
package euq_pkg;

   // internal Q.30 word: covers +-pi with headroom for CORDIC growth
   localparam int W = 36;
   localparam int W_MAX_ANGLE = 32;
   localparam int DEF_ANGLE_BITS = 16;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int QUAT_BITS = 16;

   typedef logic signed [W-1:0] q30_type;
   typedef logic signed [QUAT_BITS-1:0] quat_type;

   localparam q30_type Q30_PI      = q30_type'(64'sd3373259426);
   localparam q30_type Q30_HALF_PI = q30_type'(64'sd1686629713);
   localparam q30_type Q30_GAIN    = q30_type'(64'sd652032874);
   localparam logic signed [W:0] Q14_MAX = (W+1)'(16384);

   function automatic q30_type atan_q30(input int idx);
      q30_type r;
      case (idx)
         0:  r = q30_type'(36'h03243F6A8);
         1:  r = q30_type'(36'h01DAC6705);
         2:  r = q30_type'(36'h00FADBAFC);
         3:  r = q30_type'(36'h007F56EA6);
         4:  r = q30_type'(36'h003FEAB76);
         5:  r = q30_type'(36'h001FFD55B);
         6:  r = q30_type'(36'h000FFFAAA);
         7:  r = q30_type'(36'h0007FFF55);
         8:  r = q30_type'(36'h0003FFFEA);
         9:  r = q30_type'(36'h0001FFFFD);
         10: r = q30_type'(36'h0000FFFFF);
         11: r = q30_type'(36'h00007FFFF);
         12: r = q30_type'(36'h00003FFFF);
         13: r = q30_type'(36'h00001FFFF);
         14: r = q30_type'(36'h00000FFFF);
         15: r = q30_type'(36'h000007FFF);
         16: r = q30_type'(36'h000003FFF);
         17: r = q30_type'(36'h000001FFF);
         18: r = q30_type'(36'h000000FFF);
         19: r = q30_type'(36'h0000007FF);
         20: r = q30_type'(36'h0000003FF);
         21: r = q30_type'(36'h0000001FF);
         22: r = q30_type'(36'h0000000FF);
         23: r = q30_type'(36'h00000007F);
         24: r = q30_type'(36'h00000003F);
         25: r = q30_type'(36'h00000001F);
         26: r = q30_type'(36'h00000000F);
         27: r = q30_type'(36'h000000008);
         28: r = q30_type'(36'h000000004);
         29: r = q30_type'(36'h000000002);
         30: r = q30_type'(36'h000000001);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q.30 product, round half up
   function automatic q30_type mul_q30(input q30_type a, input q30_type b);
      logic signed [2*W-1:0] p;
      p = a * b + (2*W)'(64'sd536870912);
      return p[W+29:30];
   endfunction

   // Q.30 to Q1.14 with rounding and clamp to +-1.0
   function automatic quat_type to_q14(input logic signed [W:0] v);
      logic signed [W:0] r;
      r = (v + (W+1)'(32768)) >>> 16;
      if (r > Q14_MAX) r = Q14_MAX;
      if (r < -Q14_MAX) r = -Q14_MAX;
      return r[QUAT_BITS-1:0];
   endfunction

endpackage

[design/euq_cordic_lane.sv]
module euq_cordic_lane import euq_pkg::*; #(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS,
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic                         clock,
   input  logic [CORDIC_STEPS:0]        en,
   input  logic signed [ANGLE_BITS-1:0] angle,
   output q30_type                      sin_out,
   output q30_type                      cos_out
);

   localparam int SH = W_MAX_ANGLE - ANGLE_BITS;

   q30_type x_ff [CORDIC_STEPS+1];
   q30_type y_ff [CORDIC_STEPS+1];
   q30_type z_ff [CORDIC_STEPS+1];
   logic    negc_ff [CORDIC_STEPS+1];

   q30_type half_in;
   q30_type z_in;
   logic    negc_in;

   always_comb begin
      half_in = q30_type'(angle) <<< SH;
      negc_in = 1'b0;
      z_in = half_in;
      if (half_in > Q30_HALF_PI) begin
         z_in = Q30_PI - half_in;
         negc_in = 1'b1;
      end else if (half_in < -Q30_HALF_PI) begin
         z_in = -Q30_PI - half_in;
         negc_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0] <= Q30_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= z_in;
         negc_ff[0] <= negc_in;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      q30_type dx, dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en[i+1]) begin
            negc_ff[i+1] <= negc_ff[i];
            if (!z_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q30(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q30(i);
            end
         end
      end
   end

   assign sin_out = y_ff[CORDIC_STEPS];
   assign cos_out = negc_ff[CORDIC_STEPS] ? -x_ff[CORDIC_STEPS] : x_ff[CORDIC_STEPS];

endmodule

[design/euq_merge.sv]
module euq_merge import euq_pkg::*; (
   input  logic     clock,
   input  logic [2:0] en,
   input  q30_type  s1,
   input  q30_type  c1,
   input  q30_type  s2,
   input  q30_type  c2,
   input  q30_type  s3,
   input  q30_type  c3,
   output quat_type quat_w,
   output quat_type quat_x,
   output quat_type quat_y,
   output quat_type quat_z
);

   q30_type c1c2_ff, s1s2_ff, s1c2_ff, c1s2_ff, s3_ff, c3_ff;
   q30_type p_ff [8];
   quat_type w_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         c1c2_ff <= mul_q30(c1, c2);
         s1s2_ff <= mul_q30(s1, s2);
         s1c2_ff <= mul_q30(s1, c2);
         c1s2_ff <= mul_q30(c1, s2);
         s3_ff <= s3;
         c3_ff <= c3;
      end
      if (en[1]) begin
         p_ff[0] <= mul_q30(c1c2_ff, c3_ff);
         p_ff[1] <= mul_q30(s1s2_ff, s3_ff);
         p_ff[2] <= mul_q30(s1s2_ff, c3_ff);
         p_ff[3] <= mul_q30(c1c2_ff, s3_ff);
         p_ff[4] <= mul_q30(s1c2_ff, c3_ff);
         p_ff[5] <= mul_q30(c1s2_ff, s3_ff);
         p_ff[6] <= mul_q30(c1s2_ff, c3_ff);
         p_ff[7] <= mul_q30(s1c2_ff, s3_ff);
      end
      if (en[2]) begin
         w_ff <= to_q14((W+1)'(p_ff[0]) - (W+1)'(p_ff[1]));
         x_ff <= to_q14((W+1)'(p_ff[2]) + (W+1)'(p_ff[3]));
         y_ff <= to_q14((W+1)'(p_ff[4]) + (W+1)'(p_ff[5]));
         z_ff <= to_q14((W+1)'(p_ff[6]) - (W+1)'(p_ff[7]));
      end
   end

   assign quat_w = w_ff;
   assign quat_x = x_ff;
   assign quat_y = y_ff;
   assign quat_z = z_ff;

endmodule

[design/euler_to_quaternion.sv]
// Euler angles (heading, attitude, bank; signed Q3.13 radians) to a unit
// quaternion in signed Q1.14, saturated to +-1.0.
// Input channel req_*: one beat carries the three angles. Result channel
// rsp_*: one beat carries quat_w/x/y/z. Both use valid/ready.
// Three CORDIC lanes, one per angle, run side by side; a merge stage forms
// the triple products and sums.
// Pipeline: CORDIC_STEPS + 4 registers (fold stage, CORDIC_STEPS micro-rotation
// stages, two product stages, output stage); the fold register loads at accept
// and the output stage drives rsp_valid.
// Throughput: one beat per cycle while rsp_ready is high; lanes fully pipelined.
// Each stage carries its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up while the receiver stalls and
// new beats are taken until every stage holds one. When rsp_ready stays low
// the output register holds its beat.
// Reset clears all valid bits; nothing is in flight afterwards.
module euler_to_quaternion import euq_pkg::*; #(
   parameter int ANGLE_BITS = DEF_ANGLE_BITS,
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ANGLE_BITS-1:0] req_heading_angle,
   input  logic signed [ANGLE_BITS-1:0] req_attitude_angle,
   input  logic signed [ANGLE_BITS-1:0] req_bank_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output quat_type                     rsp_quat_w,
   output quat_type                     rsp_quat_x,
   output quat_type                     rsp_quat_y,
   output quat_type                     rsp_quat_z
);

   localparam int L = CORDIC_STEPS + 4;

   logic [L-1:0] valid_ff, valid_in;
   logic [L:0]   adv;
   q30_type s1, c1, s2, c2, s3, c3;

   always_comb begin
      adv[L] = rsp_ready;
      for (int i = L - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      for (int i = 0; i < L; i++) begin
         if (i == 0) valid_in[i] = adv[i] ? req_valid : valid_ff[i];
         else valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= valid_in;
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[L-1];

   euq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_h (
      .clock(clock), .en(adv[CORDIC_STEPS:0]), .angle(req_heading_angle),
      .sin_out(s1), .cos_out(c1)
   );

   euq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_a (
      .clock(clock), .en(adv[CORDIC_STEPS:0]), .angle(req_attitude_angle),
      .sin_out(s2), .cos_out(c2)
   );

   euq_cordic_lane #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_lane_b (
      .clock(clock), .en(adv[CORDIC_STEPS:0]), .angle(req_bank_angle),
      .sin_out(s3), .cos_out(c3)
   );

   euq_merge u_merge (
      .clock(clock), .en(adv[L-1:CORDIC_STEPS+1]),
      .s1(s1), .c1(c1), .s2(s2), .c2(c2), .s3(s3), .c3(c3),
      .quat_w(rsp_quat_w), .quat_x(rsp_quat_x), .quat_y(rsp_quat_y), .quat_z(rsp_quat_z)
   );

endmodule
